/* rtl/core/kpbs_pkg.sv */
// ----------------------------------------------------------------------------
// kpbs_pkg
// Shared constants, round table and controller/datapath interface types for
// the keyed permutation block scorer.
// ----------------------------------------------------------------------------
package kpbs_pkg;

  // block limits and field widths
  localparam int MAX_BLOCK = 1024;
  localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
  localparam int OUT_W     = 11;
  localparam int SAMPLE_W  = 16;
  localparam int HALF_W    = SAMPLE_W / 2;
  localparam int KEY_W     = 32;
  localparam int ROUNDS    = 4;
  localparam int RND_W     = $clog2(ROUNDS);
  localparam int TDATA_OUT_W = ((3 * OUT_W + 1 + 7) / 8) * 8;

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  // round mixing constant
  localparam logic [31:0] MIX_MULT = 32'h045D_9F3B;

  typedef logic [255:0][HALF_W-1:0] round_table_t;

  // round function of an 8-bit value (key byte already folded in)
  function automatic round_table_t build_round_table();
    round_table_t tbl;
    logic [31:0]  v;
    for (int i = 0; i < 256; i++) begin
      v = 32'(i);
      v = v * MIX_MULT;
      v = v ^ (v >> 16);
      v = v * MIX_MULT;
      v = v ^ (v >> 16);
      tbl[i] = v[HALF_W-1:0];
    end
    return tbl;
  endfunction

  localparam round_table_t ROUND_TABLE = build_round_table();

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             step;
    logic             commit;
    logic [RND_W-1:0] rnd;
  } kpbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic commit_ok;
  } kpbs_status_t;

endpackage

/* rtl/core/kpbs_ctrl.sv */
// ----------------------------------------------------------------------------
// kpbs_ctrl
// Sequencer: takes a word, steps the Feistel rounds through the shared round
// unit and commits the word to the block counters.
// ----------------------------------------------------------------------------
module kpbs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  kpbs_pkg::kpbs_status_t stat,
  output kpbs_pkg::kpbs_cmd_t   cmd
);
  import kpbs_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state;
  logic [RND_W-1:0] rnd;
  logic             final_rnd;

  assign final_rnd = (state == S_RUN) && (rnd == LAST_RND);

  // ready when idle or when the current word retires this cycle
  assign s_tready   = (state == S_IDLE) || (final_rnd && stat.commit_ok);
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.step   = (state == S_RUN) && (rnd != LAST_RND);
  assign cmd.commit = final_rnd && stat.commit_ok;
  assign cmd.rnd    = rnd;

  // state and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_RUN;
            rnd   <= '0;
          end
        end
        S_RUN: begin
          if (rnd != LAST_RND) begin
            rnd <= rnd + 1'b1;
          end else if (stat.commit_ok) begin
            rnd <= '0;
            if (!s_tvalid) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
          rnd   <= '0;
        end
      endcase
    end
  end

endmodule

/* rtl/core/kpbs_datapath.sv */
// ----------------------------------------------------------------------------
// kpbs_datapath
// Key register, Feistel half registers with the shared round unit, block
// counters and the result register.
// ----------------------------------------------------------------------------
module kpbs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [kpbs_pkg::KEY_W-1:0]        cfg_wdata,
  input  logic [kpbs_pkg::SAMPLE_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [kpbs_pkg::TDATA_OUT_W-1:0]  m_tdata,
  input  kpbs_pkg::kpbs_cmd_t               cmd,
  output kpbs_pkg::kpbs_status_t            stat
);
  import kpbs_pkg::*;

  logic [KEY_W-1:0]  list_key;
  logic [HALF_W-1:0] left;
  logic [HALF_W-1:0] right;
  logic              last_q;
  logic [HALF_W-1:0] key_byte;
  logic [HALF_W-1:0] mix;

  logic [CNT_W-1:0]  member_cnt;
  logic [CNT_W-1:0]  word_cnt;
  logic              ovf;
  logic [CNT_W-1:0]  member_next;
  logic [CNT_W-1:0]  word_next;
  logic              ovf_next;
  logic [CNT_W-1:0]  others;
  logic [CNT_W-1:0]  score;
  logic              is_member;

  logic [OUT_W-1:0]  score_q;
  logic [OUT_W-1:0]  member_q;
  logic [OUT_W-1:0]  word_q;
  logic              ovf_q;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      list_key <= '0;
    end else if (cfg_we) begin
      list_key <= cfg_wdata;
    end
  end

  // round unit: key byte folded in, then the constant table
  assign key_byte = list_key[HALF_W*cmd.rnd +: HALF_W];
  assign mix      = ROUND_TABLE[right ^ key_byte];

  // feistel halves
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left   <= s_tdata[SAMPLE_W-1:HALF_W];
      right  <= s_tdata[HALF_W-1:0];
      last_q <= s_tlast;
    end else if (cmd.step) begin
      left  <= right;
      right <= left ^ mix;
    end
  end

  // final round leaves the current right half on top
  assign is_member = !right[HALF_W-1];

  // saturating counter update
  always_comb begin
    member_next = member_cnt;
    word_next   = word_cnt;
    ovf_next    = ovf;
    if (word_cnt < CNT_W'(MAX_BLOCK)) begin
      word_next = word_cnt + 1'b1;
      if (is_member) begin
        member_next = member_cnt + 1'b1;
      end
    end else begin
      ovf_next = 1'b1;
    end
  end

  assign others = word_next - member_next;
  assign score  = (member_next > others) ? member_next : others;

  // block counters
  always_ff @(posedge clk) begin
    if (rst) begin
      member_cnt <= '0;
      word_cnt   <= '0;
      ovf        <= 1'b0;
    end else if (cmd.commit) begin
      if (last_q) begin
        member_cnt <= '0;
        word_cnt   <= '0;
        ovf        <= 1'b0;
      end else begin
        member_cnt <= member_next;
        word_cnt   <= word_next;
        ovf        <= ovf_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit && last_q) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && last_q) begin
      score_q  <= OUT_W'(score);
      member_q <= OUT_W'(member_next);
      word_q   <= OUT_W'(word_next);
      ovf_q    <= ovf_next;
    end
  end

  assign m_tdata = TDATA_OUT_W'({ovf_q, word_q, member_q, score_q});

  // a last word may retire only when the result slot frees up
  assign stat.commit_ok = !last_q || !m_tvalid || m_tready;

endmodule

/* rtl/core/keyed_permutation_block_score.sv */
// ----------------------------------------------------------------------------
// keyed_permutation_block_score
// Top level: stream in, Feistel permutation, block membership score out.
// ----------------------------------------------------------------------------
// Each 16-bit word is permuted by a 3-round 8+8-bit Feistel network keyed by
// cfg_wdata (one key byte per round, byte 0 first); a word is a member when
// bit 15 of the permuted value is clear. On the word with tlast set, one
// result is sent with max(members, words - members), both counts and an
// overflow flag, and the counters restart. Counters saturate at MAX_BLOCK
// words. Each word passes three rounds through the shared round table, then
// a final step in which it is counted and the next word can be taken in. The
// key must be written only while no word is in flight (the block does not
// enforce this) and applies from the next word on; no read-back.
module keyed_permutation_block_score (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [kpbs_pkg::KEY_W-1:0]        cfg_wdata,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [kpbs_pkg::SAMPLE_W-1:0]     s_tdata,   // sample
  input  logic                              s_tlast,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // block_score, member_total, word_total, count_overflow, zero fill
  output logic [kpbs_pkg::TDATA_OUT_W-1:0]  m_tdata
);
  import kpbs_pkg::*;

  kpbs_cmd_t    cmd;
  kpbs_status_t stat;

  kpbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kpbs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTHESIS
  // members never outnumber counted words
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2*OUT_W-1:OUT_W] <= m_tdata[3*OUT_W-1:2*OUT_W]))
    else $error("member_total above word_total");

  // score is at least half the block
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({m_tdata[OUT_W-1:0], 1'b0} >= {1'b0, m_tdata[3*OUT_W-1:2*OUT_W]}))
    else $error("block_score below half of word_total");

  // overflow only with a full block
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3*OUT_W]) |->
      (m_tdata[3*OUT_W-1:2*OUT_W] == OUT_W'(MAX_BLOCK)))
    else $error("overflow flagged on a short block");

  // a new word is never taken while rounds are still being stepped
  assert property (@(posedge clk) disable iff (rst)
    (s_tready && cmd.commit == 1'b0) |-> (cmd.step == 1'b0))
    else $error("input taken during rounds");
`endif

endmodule
